@@ sv/lkvc_pkg.sv @@
// Shared constants, codes and control structures of the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    // Storage defaults and fixed field widths
    localparam int ENTRIES_DEF = 16;
    localparam int CAP_W       = 5;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int USE_W       = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [VAL_W-1:0] MISS_DATA = 32'hFFFF_FFFF;
    localparam logic [VAL_W-1:0] PUT_DATA  = 32'h0000_0000;

    // Operation codes carried on the input tuser
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the accepted item, restart the scan
        logic scan;      // issue the next entry read and evaluate the last
        logic write;     // update the stores and form the result
        logic out_load;  // move the result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done; // every occupied entry has been evaluated
        logic out_free;  // output register empty or being taken
    } dp_status_t;

endpackage

`default_nettype wire

@@ sv/lkvc_ctrl.sv @@
// Controller state machine of the LRU key/value cache: accept, scan, write, hand over.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  lkvc_pkg::dp_status_t status,
    output lkvc_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Take a new item only when no item is in progress
    assign in_ready = (state_reg == ST_IDLE);

    // Derive next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.scan     = 1'b0;
        cmd.write    = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold the result until the output register can take it
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/lkvc_dp.sv @@
// Datapath of the LRU key/value cache: entry stores, scan, replacement choice and output register.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_dp
#(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  lkvc_pkg::ctrl_cmd_t              cmd,
    output lkvc_pkg::dp_status_t             status,
    input  wire                              in_cmd,
    input  wire  [lkvc_pkg::KEY_W-1:0]       in_key,
    input  wire  [lkvc_pkg::VAL_W-1:0]       in_data,
    input  wire                              cfg_we,
    input  wire  [lkvc_pkg::CAP_W-1:0]       cfg_cap,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic                             out_found,
    output logic                             out_evicted,
    output logic [lkvc_pkg::VAL_W-1:0]       out_data
);

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

    localparam int KEY_W = lkvc_pkg::KEY_W;
    localparam int VAL_W = lkvc_pkg::VAL_W;
    localparam int USE_W = lkvc_pkg::USE_W;

    // Entry stores
    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [VAL_W-1:0] val_mem [ENTRIES];
    logic [USE_W-1:0] use_mem [ENTRIES];

    // Control state
    logic [lkvc_pkg::CAP_W-1:0] cap_reg;
    logic [OCC_W-1:0]           occ_reg;
    logic [OCC_W-1:0]           occ_next;
    logic [USE_W-1:0]           clock_reg;
    logic [USE_W-1:0]           clock_next;
    logic [OCC_W-1:0]           idx_reg;
    logic                       rd_vld_reg;
    logic                       hit_reg;
    logic                       out_valid_reg;

    // Payload registers
    logic                       cmd_reg;
    logic [KEY_W-1:0]           key_reg;
    logic [VAL_W-1:0]           din_reg;
    logic [ADDR_W-1:0]          rd_idx_reg;
    logic [KEY_W-1:0]           rd_key_reg;
    logic [VAL_W-1:0]           rd_val_reg;
    logic [USE_W-1:0]           rd_use_reg;
    logic [ADDR_W-1:0]          hit_slot_reg;
    logic [VAL_W-1:0]           hit_val_reg;
    logic [ADDR_W-1:0]          vic_slot_reg;
    logic [USE_W-1:0]           vic_use_reg;
    logic                       res_found_reg;
    logic                       res_evicted_reg;
    logic [VAL_W-1:0]           res_data_reg;
    logic                       res_found_next;
    logic                       res_evicted_next;
    logic [VAL_W-1:0]           res_data_next;
    logic                       out_found_reg;
    logic                       out_evicted_reg;
    logic [VAL_W-1:0]           out_data_reg;

    // Write-back controls
    logic                       rd_en;
    logic                       kv_we;
    logic                       use_we;
    logic [ADDR_W-1:0]          wr_addr;
    logic [CMP_W-1:0]           eff_cap;
    logic                       has_room;

    // Clamp the configured capacity to 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    assign has_room = (CMP_W'(occ_reg) < eff_cap);

    // Read one occupied entry per scan cycle
    assign rd_en = cmd.scan && (idx_reg < occ_reg);

    assign status.scan_done = (idx_reg == occ_reg) && !rd_vld_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    // Decide the write-back and the result
    always_comb
    begin
        kv_we            = 1'b0;
        use_we           = 1'b0;
        wr_addr          = hit_slot_reg;
        occ_next         = occ_reg;
        clock_next       = clock_reg;
        res_found_next   = 1'b0;
        res_evicted_next = 1'b0;
        res_data_next    = lkvc_pkg::PUT_DATA;
        if (cmd_reg == lkvc_pkg::CMD_GET)
        begin
            if (hit_reg)
            begin
                use_we         = 1'b1;
                clock_next     = clock_reg + USE_W'(1);
                res_found_next = 1'b1;
                res_data_next  = hit_val_reg;
            end
            else
            begin
                res_data_next = lkvc_pkg::MISS_DATA;
            end
        end
        else
        begin
            kv_we      = 1'b1;
            use_we     = 1'b1;
            clock_next = clock_reg + USE_W'(1);
            if (hit_reg)
            begin
                res_found_next = 1'b1;
            end
            else if (has_room)
            begin
                // Fill the next free slot
                wr_addr  = occ_reg[ADDR_W-1:0];
                occ_next = occ_reg + OCC_W'(1);
            end
            else
            begin
                // Replace the least recently used entry
                wr_addr          = vic_slot_reg;
                res_evicted_next = 1'b1;
            end
        end
    end

    // Entry stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.write && kv_we)
        begin
            key_mem[wr_addr] <= key_reg;
            val_mem[wr_addr] <= din_reg;
        end
        if (cmd.write && use_we)
        begin
            use_mem[wr_addr] <= clock_next;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[idx_reg[ADDR_W-1:0]];
            rd_val_reg <= val_mem[idx_reg[ADDR_W-1:0]];
            rd_use_reg <= use_mem[idx_reg[ADDR_W-1:0]];
            rd_idx_reg <= idx_reg[ADDR_W-1:0];
        end
    end

    // Control state: capacity, occupancy, access clock, scan progress, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lkvc_pkg::CAP_RESET;
            occ_reg       <= '0;
            clock_reg     <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_cap;
            end
            if (cmd.load)
            begin
                idx_reg    <= '0;
                rd_vld_reg <= 1'b0;
                hit_reg    <= 1'b0;
            end
            else
            begin
                rd_vld_reg <= rd_en;
                if (rd_en)
                begin
                    idx_reg <= idx_reg + OCC_W'(1);
                end
                // Keep the first matching entry only
                if (rd_vld_reg && (rd_key_reg == key_reg))
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.write)
            begin
                occ_reg   <= occ_next;
                clock_reg <= clock_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: item capture, scan results, result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_cmd;
            key_reg <= in_key;
            din_reg <= in_data;
        end
        if (rd_vld_reg && !cmd.load)
        begin
            if (!hit_reg && (rd_key_reg == key_reg))
            begin
                hit_slot_reg <= rd_idx_reg;
                hit_val_reg  <= rd_val_reg;
            end
            // Strictly older wins; the first entry seeds the search
            if ((rd_idx_reg == '0) || (rd_use_reg < vic_use_reg))
            begin
                vic_slot_reg <= rd_idx_reg;
                vic_use_reg  <= rd_use_reg;
            end
        end
        if (cmd.write)
        begin
            res_found_reg   <= res_found_next;
            res_evicted_reg <= res_evicted_next;
            res_data_reg    <= res_data_next;
        end
        if (cmd.out_load)
        begin
            out_found_reg   <= res_found_reg;
            out_evicted_reg <= res_evicted_reg;
            out_data_reg    <= res_data_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_found   = out_found_reg;
    assign out_evicted = out_evicted_reg;
    assign out_data    = out_data_reg;

endmodule

`default_nettype wire

@@ sv/lru_key_value_cache.sv @@
// Top level of the LRU key/value cache: stream ports, controller and datapath.
//
// Usage:
//   Input stream s_*: one item per get or put; tuser carries the operation
//   (0 get, 1 put), tdata carries key and value. Output stream m_*: one item
//   per input item with the found and evicted flags on tuser and the value
//   on tdata (stored value on a get hit, all ones on a get miss, 0 on a put).
//   Configuration channel cfg_*: writes the capacity (1..ENTRIES, 0 acts as
//   1, larger values act as ENTRIES); write it only while the block is idle.
//   cfg_ready is always high.
//   Timing: an item is scanned against the occupied entries one entry per
//   cycle through the single read port of the entry stores, followed by a
//   write-back step that updates the stores and forms the result.
//   One item is processed at a time; s_tready is high only when idle, so a
//   new item is taken only once the last result is in the output register.
//   Stall: the result waits in the output register while m_tready is low;
//   the next item is accepted and scanned meanwhile and holds before its
//   hand-over until the register is free.
//   Reset: empties the cache, clears the access clock and the output, and
//   sets the capacity to 16. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache
#(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    // Input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [31:0] key, [63:32] data_in
    input  wire  [0:0]  s_tuser,   // [0] cmd
    // Output stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] data_out
    output logic [1:0]  m_tuser,   // [0] found, [1] evicted
    // Capacity register write
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [4:0]  cfg_data   // [4:0] capacity
);

    lkvc_pkg::ctrl_cmd_t  cmd;
    lkvc_pkg::dp_status_t status;
    logic                 found;
    logic                 evicted;

    assign cfg_ready = 1'b1;

    lkvc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lkvc_dp
    #(
        .ENTRIES (ENTRIES)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_cmd      (s_tuser[0]),
        .in_key      (s_tdata[31:0]),
        .in_data     (s_tdata[63:32]),
        .cfg_we      (cfg_valid),
        .cfg_cap     (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_found   (found),
        .out_evicted (evicted),
        .out_data    (m_tdata)
    );

    assign m_tuser = {evicted, found};

endmodule

`default_nettype wire

@@ sv/lkvc_checker.sv @@
// Port-level assertions of the LRU key/value cache and their binding.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire [1:0]  m_tuser
);

    // Hold a stalled result unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Drop ready for the cycle after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // Never report a hit and an eviction together
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("found and evicted both set");

    // An eviction comes from a put, which returns zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == 32'h0000_0000)
        else $error("eviction with non-zero data");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking stream testbench of the LRU key/value cache with its own cache predictor.
`timescale 1ns / 1ps

module tb;

    localparam int ENTRIES       = lkvc_pkg::ENTRIES_DEF;
    localparam int CLK_HALF      = 6;
    localparam int MAX_WAIT      = 17;
    localparam int ITEMS_PER_SET = 140;
    localparam int DRAIN_CYCLES  = 40;
    localparam int IDLE_LIMIT    = 3000;

    typedef struct {
        logic        cmd;
        logic [31:0] key;
        logic [31:0] data;
    } cache_request_t;

    typedef struct packed {
        logic        found;
        logic [31:0] value;
        logic        evicted;
    } cache_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;       // [31:0] key, [63:32] data_in
    logic [0:0]  s_tuser = '0;       // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [31:0] data_out
    logic [1:0]  m_tuser;            // [0] found, [1] evicted
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;      // [4:0] capacity

    // Predicted cache contents
    logic [31:0]     cache_keys [ENTRIES];
    logic [31:0]     cache_values [ENTRIES];
    logic [63:0]     cache_last_use [ENTRIES];
    int              cache_fill = 0;
    logic [63:0]     use_clock = '0;
    logic [lkvc_pkg::CAP_W-1:0] cache_capacity = lkvc_pkg::CAP_RESET;

    cache_request_t  request_q [$];
    cache_result_t   awaited_results_q [$];
    logic [4:0]      capacity_q [$];

    int items_queued = 0;
    int results_seen = 0;
    int capacity_writes = 0;
    int mismatch_count = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;
    int idle_cycles = 0;

    lru_key_value_cache u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Store an entry and stamp it with the advanced use clock
    function automatic void store_entry(int slot, logic [31:0] key, logic [31:0] value);
        use_clock           = use_clock + 64'd1;
        cache_keys[slot]     = key;
        cache_values[slot]   = value;
        cache_last_use[slot] = use_clock;
    endfunction

    // Apply one get or put to the predicted cache and return the result it causes
    function automatic cache_result_t apply_request(logic cmd, logic [31:0] key,
                                                    logic [31:0] value);
        cache_result_t res;
        int            slot;
        int            victim;
        int            usable;
        res.found   = 1'b0;
        res.value   = lkvc_pkg::PUT_DATA;
        res.evicted = 1'b0;
        slot = -1;
        for (int i = 0; i < cache_fill; i++)
        begin
            if (slot < 0 && cache_keys[i] == key)
                slot = i;
        end
        usable = (cache_capacity == 0) ? 1 :
                 (cache_capacity > ENTRIES) ? ENTRIES : int'(cache_capacity);
        if (cmd == lkvc_pkg::CMD_GET)
        begin
            if (slot >= 0)
            begin
                use_clock            = use_clock + 64'd1;
                cache_last_use[slot] = use_clock;
                res.found            = 1'b1;
                res.value            = cache_values[slot];
            end
            else
                res.value = lkvc_pkg::MISS_DATA;
        end
        else if (slot >= 0)
        begin
            res.found = 1'b1;
            store_entry(slot, key, value);
        end
        else if (cache_fill < usable)
        begin
            store_entry(cache_fill, key, value);
            cache_fill++;
        end
        else
        begin
            // Oldest use time loses its slot, lowest index on ties
            victim = 0;
            for (int i = 1; i < cache_fill; i++)
            begin
                if (cache_last_use[i] < cache_last_use[victim])
                    victim = i;
            end
            store_entry(victim, key, value);
            res.evicted = 1'b1;
        end
        return res;
    endfunction

    function automatic int draw_wait(ref bit steady);
        if ($urandom_range(0, 31) == 0)
            steady = ~steady;
        return steady ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic report_mismatch(string what, cache_result_t want, cache_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"tb: %s: expected found=%0b data=%h evicted=%0b,",
                      " got found=%0b data=%h evicted=%0b"},
                     what, want.found, want.value, want.evicted,
                     got.found, got.value, got.evicted);
    endtask

    // Drive capacity writes and request items, predict each accepted item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= '0;
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
            send_wait = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cache_capacity = cfg_data;
                capacity_writes++;
                cfg_valid <= 1'b0;
            end
            else if (!cfg_valid && capacity_q.size() != 0)
            begin
                cfg_data  <= capacity_q.pop_front();
                cfg_valid <= 1'b1;
            end

            if (s_tvalid && s_tready)
                awaited_results_q.push_back(apply_request(s_tuser[0], s_tdata[31:0],
                                                          s_tdata[63:32]));

            if (!s_tvalid || s_tready)
            begin
                if (send_wait != 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    cache_request_t req;
                    req = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= req.cmd;
                    s_tdata  <= {req.data, req.key};
                    send_wait = draw_wait(send_steady);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Take results with random stalls and check them against the predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                cache_result_t got;
                got.found   = m_tuser[0];
                got.value   = m_tdata;
                got.evicted = m_tuser[1];
                results_seen++;
                if (awaited_results_q.size() == 0)
                    report_mismatch("result with nothing awaited", '0, got);
                else
                begin
                    cache_result_t want;
                    want = awaited_results_q.pop_front();
                    if (got !== want)
                        report_mismatch("result mismatch", want, got);
                end
                recv_wait = draw_wait(recv_steady);
            end
            if (recv_wait != 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic queue_request(logic cmd, logic [31:0] key, logic [31:0] data);
        cache_request_t req;
        req.cmd  = cmd;
        req.key  = key;
        req.data = data;
        request_q.push_back(req);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen < items_queued)
            @(negedge clk);
    endtask

    task automatic write_capacity(logic [4:0] value);
        int target;
        target = capacity_writes + 1;
        capacity_q.push_back(value);
        while (capacity_writes < target)
            @(negedge clk);
    endtask

    // Stimulus: directed items, then random sets under a series of capacities
    initial
    begin
        logic [4:0]  capacities [10] = '{5'd0, 5'd2, 5'd5, 5'd8, 5'd31,
                                         5'd17, 5'd1, 5'd16, 5'd4, 5'd12};
        logic [31:0] key_pool [$];
        logic [31:0] key;
        logic [31:0] data;
        int          usable;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Misses on an empty cache, fill with extreme keys and values
        queue_request(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_request(lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(lkvc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        // Hits, including a stored all-ones value that looks like a miss
        queue_request(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_request(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h1234_5678);
        queue_request(lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        // Update in place, then misses next to stored keys
        queue_request(lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h5555_AAAA);
        queue_request(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'hDEAD_BEEF);
        queue_request(lkvc_pkg::CMD_GET, 32'h8000_0001, 32'hFFFF_FFFF);
        queue_request(lkvc_pkg::CMD_GET, 32'h7FFF_FFFE, 32'h0000_0000);
        queue_request(lkvc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hAAAA_5555);
        queue_request(lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_drained();

        // Capacities below the fill, zero, above the size and the extremes
        foreach (capacities[p])
        begin
            write_capacity(capacities[p]);
            usable = (capacities[p] == 0) ? 1 :
                     (capacities[p] > ENTRIES) ? ENTRIES : int'(capacities[p]);

            // Mix stored keys with fresh ones so hits, fills and evictions all occur
            key_pool.delete();
            for (int i = 0; i < cache_fill; i++)
                key_pool.push_back(cache_keys[i]);
            for (int i = 0; i < usable / 2 + 3; i++)
                key_pool.push_back(($urandom_range(0, 7) == 0) ? edge_word() : $urandom());

            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    key = $urandom();
                else
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                data = ($urandom_range(0, 15) == 0) ? edge_word() : $urandom();
                queue_request(logic'($urandom_range(0, 1)), key, data);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (awaited_results_q.size() != 0)
        begin
            mismatch_count += awaited_results_q.size();
            $display("tb: %0d results never arrived", awaited_results_q.size());
        end
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
